// ===== sv/water_heater_thermostat_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Water heater thermostat - assertion macros
// Shared concurrent assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef WATER_HEATER_THERMOSTAT_UNIT_MACROS_SVH
`define WATER_HEATER_THERMOSTAT_UNIT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define WHT_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define WHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/wht_pkg.sv =====
// ---------------------------------------------------------------------------
// Water heater thermostat - package
// Widths, reset values, register indexes, shared structs and digit decode.
// ---------------------------------------------------------------------------
package wht_pkg;

  localparam int SP_W       = 9;   // setpoint and scaled temperature
  localparam int PARAM_W    = 6;   // band and step size
  localparam int SEG_W      = 7;
  localparam int CNT_W      = 4;
  localparam int DIGIT_W    = 6;   // tens digit reaches 50
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam int SCALE_MAX  = 500;
  localparam int DEC_BASE   = 10;
  // x / 10 == (x * 205) >> 11 for every x below 1029
  localparam int DIV10_MUL  = 205;
  localparam int DIV10_SH   = 11;
  localparam int DIV10_PW   = SP_W + 8;

  localparam logic [SEG_W-1:0]   SEG_BLANK   = 7'h7F;
  localparam logic [SP_W-1:0]    RST_MIN_SP  = 9'd35;
  localparam logic [SP_W-1:0]    RST_MAX_SP  = 9'd75;
  localparam logic [SP_W-1:0]    RST_INIT_SP = 9'd60;
  localparam logic [PARAM_W-1:0] RST_BAND    = 6'd5;
  localparam logic [PARAM_W-1:0] RST_STEP    = 6'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_SP  = 3'd0,
    REG_MAX_SP  = 3'd1,
    REG_INIT_SP = 3'd2,
    REG_BAND    = 3'd3,
    REG_STEP    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [SP_W-1:0]    min_sp;
    logic [SP_W-1:0]    max_sp;
    logic [SP_W-1:0]    init_sp;
    logic [PARAM_W-1:0] band;
    logic [PARAM_W-1:0] step;
  } cfg_t;

  typedef struct packed {
    logic            load;
    logic [SP_W-1:0] value;
  } sp_load_t;

  typedef struct packed {
    logic [SP_W-1:0]  scaled;
    logic [SEG_W-1:0] seg_ones;
    logic [SEG_W-1:0] seg_tens;
  } disp_t;

  typedef struct packed {
    logic             heater_on;
    logic             cooler_on;
    logic             cool_indicator;
    logic [SEG_W-1:0] seg_ones;
    logic [SEG_W-1:0] seg_tens;
    logic [SP_W-1:0]  current_setpoint;
    logic             decision_made;
  } res_t;

  // Active-low segments, gfedcba; anything above nine blanks
  function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      6'd0:    s = 7'b1000000;
      6'd1:    s = 7'b1111001;
      6'd2:    s = 7'b0100100;
      6'd3:    s = 7'b0110000;
      6'd4:    s = 7'b0011001;
      6'd5:    s = 7'b0010010;
      6'd6:    s = 7'b0000010;
      6'd7:    s = 7'b1111000;
      6'd8:    s = 7'b0000000;
      6'd9:    s = 7'b0010000;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/wht_sample_if.sv =====
// ---------------------------------------------------------------------------
// Water heater thermostat - sample channel
// One sensor reading and button snapshot per transfer.
// ---------------------------------------------------------------------------
interface wht_sample_if #(
  parameter int ADC_BITS = 10
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_sample;
  logic                up_pressed;
  logic                down_pressed;
  logic                power_toggle;

  modport source (output valid, adc_sample, up_pressed, down_pressed, power_toggle,
                  input ready);
  modport sink   (input valid, adc_sample, up_pressed, down_pressed, power_toggle,
                  output ready);
endinterface

// ===== sv/wht_result_if.sv =====
// ---------------------------------------------------------------------------
// Water heater thermostat - result channel
// Drive levels, display segments and setpoint, one transfer per sample.
// ---------------------------------------------------------------------------
interface wht_result_if;
  import wht_pkg::*;
  logic             valid;
  logic             ready;
  logic             heater_on;
  logic             cooler_on;
  logic             cool_indicator;
  logic [SEG_W-1:0] seg_ones;
  logic [SEG_W-1:0] seg_tens;
  logic [SP_W-1:0]  current_setpoint;
  logic             decision_made;

  modport source (output valid, heater_on, cooler_on, cool_indicator, seg_ones, seg_tens,
                         current_setpoint, decision_made,
                  input ready);
  modport sink   (input valid, heater_on, cooler_on, cool_indicator, seg_ones, seg_tens,
                        current_setpoint, decision_made,
                  output ready);
endinterface

// ===== sv/wht_cfg_if.sv =====
// ---------------------------------------------------------------------------
// Water heater thermostat - configuration channel
// Register index and write data, one register per transfer.
// ---------------------------------------------------------------------------
interface wht_cfg_if;
  import wht_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/wht_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// Water heater thermostat - configuration registers
// Holds limits, band and step; a write of the initial setpoint also reloads it.
// ---------------------------------------------------------------------------
module wht_cfg_regs
  import wht_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  wht_cfg_if.sink         cfg,
  output cfg_t            regs,
  output sp_load_t        sp_load
);

  logic wr;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.min_sp  <= RST_MIN_SP;
      regs.max_sp  <= RST_MAX_SP;
      regs.init_sp <= RST_INIT_SP;
      regs.band    <= RST_BAND;
      regs.step    <= RST_STEP;
    end else if (wr) begin
      unique case (cfg_idx_t'(cfg.index))
        REG_MIN_SP:  regs.min_sp  <= cfg.data[SP_W-1:0];
        REG_MAX_SP:  regs.max_sp  <= cfg.data[SP_W-1:0];
        REG_INIT_SP: regs.init_sp <= cfg.data[SP_W-1:0];
        REG_BAND:    regs.band    <= cfg.data[PARAM_W-1:0];
        REG_STEP:    regs.step    <= cfg.data[PARAM_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  assign sp_load.load  = wr && (cfg.index == REG_INIT_SP);
  assign sp_load.value = cfg.data[SP_W-1:0];

endmodule

// ===== sv/wht_display.sv =====
// ---------------------------------------------------------------------------
// Water heater thermostat - scaling and digit decode
// Scales the reading to 0..500 and splits it into two segment digits.
// ---------------------------------------------------------------------------
module wht_display
  import wht_pkg::*;
#(
  parameter int ADC_BITS = 10
) (
  input  logic [ADC_BITS-1:0] adc,
  output disp_t               disp
);

  localparam int XW = ADC_BITS + SP_W;
  localparam logic [ADC_BITS-1:0] FULL = '1;

  logic [XW-1:0]         x;
  logic [SP_W-1:0]       q0;
  logic [ADC_BITS+1:0]   r1;
  logic [1:0]            q1;
  logic [ADC_BITS:0]     r2;
  logic                  fix;
  logic [SP_W:0]         qsum;
  logic [SP_W-1:0]       scaled;
  logic [DIV10_PW-1:0]   prod;
  logic [DIGIT_W-1:0]    tens;
  logic [SP_W-1:0]       tens_x10;
  logic [SP_W-1:0]       ones;

  // x / (2^B - 1): fold the high part back in twice, then one compare
  assign x    = XW'(adc) * XW'(SCALE_MAX);
  assign q0   = x[XW-1:ADC_BITS];
  assign r1   = (ADC_BITS+2)'(x[ADC_BITS-1:0]) + (ADC_BITS+2)'(q0);
  assign q1   = r1[ADC_BITS+1:ADC_BITS];
  assign r2   = (ADC_BITS+1)'(r1[ADC_BITS-1:0]) + (ADC_BITS+1)'(q1);
  assign fix  = (r2 >= {1'b0, FULL});
  assign qsum = (SP_W+1)'(q0) + (SP_W+1)'(q1) + (SP_W+1)'(fix);
  assign scaled = qsum[SP_W-1:0];

  assign prod     = DIV10_PW'(scaled) * DIV10_PW'(DIV10_MUL);
  assign tens     = prod[DIV10_SH +: DIGIT_W];
  assign tens_x10 = SP_W'(tens) * SP_W'(DEC_BASE);
  assign ones     = scaled - tens_x10;

  assign disp.scaled   = scaled;
  assign disp.seg_ones = seg_of(ones[DIGIT_W-1:0]);
  assign disp.seg_tens = seg_of(tens);

endmodule

// ===== sv/wht_core.sv =====
// ---------------------------------------------------------------------------
// Water heater thermostat - control core
// Power, sample count, drive levels, held digits and setpoint stepping.
// ---------------------------------------------------------------------------
module wht_core
  import wht_pkg::*;
#(
  parameter int SAMPLES_PER_DECISION = 10
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     advance,
  input  logic     up,
  input  logic     down,
  input  logic     toggle,
  input  disp_t    disp,
  input  cfg_t     regs,
  input  sp_load_t sp_load,
  output res_t     res
);

  logic             power, power_next;
  logic [CNT_W-1:0] count, count_next;
  logic             heater, heater_next;
  logic             cooler, cooler_next;
  logic             indicator, indicator_next;
  logic [SEG_W-1:0] ones_seg, ones_seg_next;
  logic [SEG_W-1:0] tens_seg, tens_seg_next;
  logic [SP_W-1:0]  setpoint, setpoint_next;

  logic [CNT_W-1:0] cnt_inc;
  logic             decide;
  logic [SP_W:0]    low_cmp, high_cmp, sum_up, dn_thr;
  logic [SP_W-1:0]  sp_a, sp_b;

  always_comb begin
    power_next     = power ^ toggle;
    cnt_inc        = count + CNT_W'(1);
    decide         = 1'b0;
    count_next     = count;
    heater_next    = heater;
    cooler_next    = cooler;
    indicator_next = indicator;
    ones_seg_next  = ones_seg;
    tens_seg_next  = tens_seg;
    setpoint_next  = setpoint;

    // heater: scaled < sp - band, taken as scaled + band < sp
    low_cmp  = (SP_W+1)'(disp.scaled) + (SP_W+1)'(regs.band);
    high_cmp = (SP_W+1)'(setpoint) + (SP_W+1)'(regs.band);

    // up first, then down
    sum_up = (SP_W+1)'(setpoint) + (SP_W+1)'(regs.step);
    sp_a   = setpoint;
    if (up && (setpoint < regs.max_sp)) begin
      sp_a = (sum_up > (SP_W+1)'(regs.max_sp)) ? regs.max_sp : sum_up[SP_W-1:0];
    end
    dn_thr = (SP_W+1)'(regs.min_sp) + (SP_W+1)'(regs.step);
    sp_b   = sp_a;
    if (down && (sp_a > regs.min_sp)) begin
      sp_b = ((SP_W+1)'(sp_a) >= dn_thr) ? sp_a - SP_W'(regs.step) : regs.min_sp;
    end

    if (power_next) begin
      count_next = cnt_inc;
      if (cnt_inc >= CNT_W'(SAMPLES_PER_DECISION)) begin
        decide         = 1'b1;
        count_next     = '0;
        ones_seg_next  = disp.seg_ones;
        tens_seg_next  = disp.seg_tens;
        heater_next    = (low_cmp < (SP_W+1)'(setpoint));
        cooler_next    = ((SP_W+1)'(disp.scaled) > high_cmp);
        indicator_next = cooler_next;
      end
      setpoint_next = sp_b;
    end else begin
      heater_next    = 1'b0;
      cooler_next    = 1'b0;
      indicator_next = 1'b0;
      ones_seg_next  = SEG_BLANK;
      tens_seg_next  = SEG_BLANK;
    end
  end

  always_comb begin
    res.heater_on        = heater_next;
    res.cooler_on        = cooler_next;
    res.cool_indicator   = indicator_next;
    res.seg_ones         = ones_seg_next;
    res.seg_tens         = tens_seg_next;
    res.current_setpoint = setpoint_next;
    res.decision_made    = decide;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power     <= 1'b0;
      count     <= '0;
      heater    <= 1'b0;
      cooler    <= 1'b0;
      indicator <= 1'b0;
      ones_seg  <= SEG_BLANK;
      tens_seg  <= SEG_BLANK;
      setpoint  <= RST_INIT_SP;
    end else if (sp_load.load) begin
      setpoint  <= sp_load.value;
    end else if (advance) begin
      power     <= power_next;
      count     <= count_next;
      heater    <= heater_next;
      cooler    <= cooler_next;
      indicator <= indicator_next;
      ones_seg  <= ones_seg_next;
      tens_seg  <= tens_seg_next;
      setpoint  <= setpoint_next;
    end
  end

endmodule

// ===== sv/water_heater_thermostat_unit.sv =====
// ---------------------------------------------------------------------------
// Water heater thermostat - top level
// Deadband heat/cool controller with a two-digit temperature display.
// ---------------------------------------------------------------------------
//  channel  | dir | carries                                     | transfer when
//  ---------+-----+---------------------------------------------+--------------
//  sample   | in  | adc_sample, up/down buttons, power toggle   | valid & ready
//  result   | out | heater, cooler, lamp, digits, setpoint, tick | valid & ready
//  cfg      | in  | register index, write data                  | valid & ready
//
//  One sample per cycle sustained while results are taken. A sample is held
//  in the input register and is decided on its way into the result
//  register, from which the result is offered.
//  Reset (rst, synchronous) empties both registers, restores the register
//  defaults, powers the unit off and blanks the display.
//  A stalled result holds the result register; the input register then
//  holds too and sample.ready drops only once both are full.
//  cfg is always ready; it is to be written only while no sample is in flight, which the block does not enforce.
// ---------------------------------------------------------------------------
module water_heater_thermostat_unit
  import wht_pkg::*;
#(
  parameter int SAMPLES_PER_DECISION = 10,
  parameter int ADC_BITS             = 10
) (
  input  logic          clk,
  input  logic          rst,
  wht_sample_if.sink    sample,
  wht_result_if.source  result,
  wht_cfg_if.sink       cfg
);

  // input register
  logic                s1_valid;
  logic [ADC_BITS-1:0] s1_adc;
  logic                s1_up;
  logic                s1_down;
  logic                s1_toggle;

  // result register
  logic out_valid;
  res_t out_res;

  logic     out_free;   // result register can take a new value
  logic     advance;    // the held sample is decided this cycle
  cfg_t     regs;
  sp_load_t sp_load;
  disp_t    disp;
  res_t     res;

  assign out_free     = !out_valid || result.ready;
  assign advance      = s1_valid && out_free;
  assign sample.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      s1_adc    <= sample.adc_sample;
      s1_up     <= sample.up_pressed;
      s1_down   <= sample.down_pressed;
      s1_toggle <= sample.power_toggle;
    end
  end

  wht_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .regs    (regs),
    .sp_load (sp_load)
  );

  // scaling and digit split for the held sample
  wht_display #(
    .ADC_BITS (ADC_BITS)
  ) u_disp (
    .adc  (s1_adc),
    .disp (disp)
  );

  // controller state moves once per decided sample, or on a setpoint load
  wht_core #(
    .SAMPLES_PER_DECISION (SAMPLES_PER_DECISION)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .up      (s1_up),
    .down    (s1_down),
    .toggle  (s1_toggle),
    .disp    (disp),
    .regs    (regs),
    .sp_load (sp_load),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign result.valid            = out_valid;
  assign result.heater_on        = out_res.heater_on;
  assign result.cooler_on        = out_res.cooler_on;
  assign result.cool_indicator   = out_res.cool_indicator;
  assign result.seg_ones         = out_res.seg_ones;
  assign result.seg_tens         = out_res.seg_tens;
  assign result.current_setpoint = out_res.current_setpoint;
  assign result.decision_made    = out_res.decision_made;

endmodule

// ===== sv/wht_checker.sv =====
// ---------------------------------------------------------------------------
// Water heater thermostat - port checker
// Watches the result channel of the top level and is bound to it.
// ---------------------------------------------------------------------------
`include "water_heater_thermostat_unit_macros.svh"

module wht_checker
  import wht_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_ready,
  input logic            heater_on,
  input logic            cooler_on,
  input logic            cool_indicator,
  input logic [SP_W-1:0] current_setpoint
);

  // no result straight out of reset
  `WHT_ASSERT_NEXT(a_rst_empty, clk, 1'b0, rst, !out_valid, "result valid after reset")

  // heating and cooling never drive together
  `WHT_ASSERT_ALWAYS(a_heat_cool_excl, clk, rst, !(out_valid && heater_on && cooler_on), "heater and cooler both on")

  // lamp follows the cooler
  `WHT_ASSERT_ALWAYS(a_lamp_cooler, clk, rst, !out_valid || (cool_indicator == cooler_on), "indicator differs from cooler")

  // stalled result holds
  `WHT_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(current_setpoint), "stalled result changed")

endmodule

bind water_heater_thermostat_unit wht_checker u_wht_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (result.valid),
  .out_ready        (result.ready),
  .heater_on        (result.heater_on),
  .cooler_on        (result.cooler_on),
  .cool_indicator   (result.cool_indicator),
  .current_setpoint (result.current_setpoint)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Water heater thermostat - testbench
// Drives samples and register writes into the thermostat unit and checks
// every result transfer against an in-bench controller model or a typed row's
// want. A short directed table comes first, then random samples under
// several register settings and patterns of source idling and sink back-pressure.
// ---------------------------------------------------------------------------
module testbench;
  import wht_pkg::*;

  localparam int DECISION_EVERY = 10;      // samples per control decision
  localparam int ADC_BITS       = 10;
  localparam int ADC_FULL       = (1 << ADC_BITS) - 1;
  localparam int HOLD_CYCLES    = 200;     // long sink hold-off
  localparam int SETTLE_LIMIT   = 5000;
  localparam int CHUNK_ITEMS    = 32;
  localparam int PRESSURE_ITEMS = 40;

  // Indexes past the end of the register list; writes there do nothing
  localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_REG = 3'd5;

  localparam logic [SEG_W-1:0] SEG_ZERO = 7'b1000000;

  // Active-low gfedcba patterns for the digits 0..9
  localparam logic [SEG_W-1:0] DIGIT_SEGS [10] = '{
    7'b1000000, 7'b1111001, 7'b0100100, 7'b0110000, 7'b0011001,
    7'b0010010, 7'b0000010, 7'b1111000, 7'b0000000, 7'b0010000
  };

  typedef struct packed {
    logic [ADC_BITS-1:0] adc;
    logic                up;
    logic                down;
    logic                toggle;
  } reading_t;

  typedef struct packed {
    reading_t rd;
    logic     typed;    // want holds the expected result
    res_t     want;
  } dir_row_t;

  localparam res_t UNTYPED = '0;

  // Directed part, run with the reset register values (band 5, step 5,
  // limits 35..75, setpoint 60). Field order of want: heater, cooler, lamp,
  // ones, tens, setpoint, decision.
  localparam int NUM_DIRECTED = 23;
  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    // powered off: buttons ignored, display blank
    '{'{10'd1023, 1'b1, 1'b1, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 1'b0, SEG_BLANK, SEG_BLANK, 9'd60, 1'b0}},
    // power on, climb to the upper limit, then one press at the limit
    '{'{10'd0,    1'b1, 1'b0, 1'b1}, 1'b1,
      '{1'b0, 1'b0, 1'b0, SEG_BLANK, SEG_BLANK, 9'd65, 1'b0}},
    '{'{10'd512,  1'b1, 1'b0, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 1'b0, SEG_BLANK, SEG_BLANK, 9'd70, 1'b0}},
    '{'{10'd1,    1'b1, 1'b0, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 1'b0, SEG_BLANK, SEG_BLANK, 9'd75, 1'b0}},
    '{'{10'd1022, 1'b1, 1'b0, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 1'b0, SEG_BLANK, SEG_BLANK, 9'd75, 1'b0}},
    // both buttons: up first (no effect at max), then down
    '{'{10'd2,    1'b1, 1'b1, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 1'b0, SEG_BLANK, SEG_BLANK, 9'd70, 1'b0}},
    '{'{10'h155,  1'b0, 1'b1, 1'b0}, 1'b0, UNTYPED},
    '{'{10'h2AA,  1'b0, 1'b1, 1'b0}, 1'b0, UNTYPED},
    '{'{10'h0F0,  1'b0, 1'b1, 1'b0}, 1'b0, UNTYPED},
    '{'{10'h30F,  1'b0, 1'b1, 1'b0}, 1'b0, UNTYPED},
    // tenth sample at full scale: 500 shows ones 0, tens blank, cooling
    '{'{10'd1023, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{1'b0, 1'b1, 1'b1, SEG_ZERO, SEG_BLANK, 9'd50, 1'b1}},
    // walk down past the lower limit
    '{'{10'd100,  1'b0, 1'b1, 1'b0}, 1'b0, UNTYPED},
    '{'{10'd200,  1'b0, 1'b1, 1'b0}, 1'b0, UNTYPED},
    '{'{10'd300,  1'b0, 1'b1, 1'b0}, 1'b0, UNTYPED},
    '{'{10'd400,  1'b0, 1'b1, 1'b0}, 1'b0, UNTYPED},
    '{'{10'd1,    1'b0, 1'b0, 1'b0}, 1'b0, UNTYPED},
    '{'{10'd1022, 1'b0, 1'b0, 1'b0}, 1'b0, UNTYPED},
    '{'{10'd511,  1'b0, 1'b0, 1'b0}, 1'b0, UNTYPED},
    '{'{10'd3,    1'b0, 1'b0, 1'b0}, 1'b0, UNTYPED},
    '{'{10'd777,  1'b0, 1'b0, 1'b0}, 1'b0, UNTYPED},
    // tenth sample at zero: 00 on the display, heating
    '{'{10'd0,    1'b0, 1'b0, 1'b0}, 1'b1,
      '{1'b1, 1'b0, 1'b0, SEG_ZERO, SEG_ZERO, 9'd35, 1'b1}},
    // power off clears drives and blanks, setpoint kept
    '{'{10'd1023, 1'b1, 1'b0, 1'b1}, 1'b1,
      '{1'b0, 1'b0, 1'b0, SEG_BLANK, SEG_BLANK, 9'd35, 1'b0}},
    '{'{10'd0,    1'b0, 1'b1, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 1'b0, SEG_BLANK, SEG_BLANK, 9'd35, 1'b0}}
  };

  // Register settings for the random part: min, max, initial, band, step
  localparam int NUM_PLANS = 7;
  localparam cfg_t CFG_PLAN [NUM_PLANS] = '{
    '{9'd0,   9'd500, 9'd250, 6'd63, 6'd63},  // widest band, step overshoots
    '{9'd0,   9'd500, 9'd0,   6'd0,  6'd1},   // no deadband, finest step
    '{9'd100, 9'd40,  9'd70,  6'd3,  6'd7},   // limits reversed
    '{9'd20,  9'd60,  9'd2,   6'd40, 6'd9},   // setpoint below band
    '{9'd500, 9'd500, 9'd500, 6'd63, 6'd0},   // top of scale, zero step
    '{9'd0,   9'd0,   9'd0,   6'd0,  6'd63},  // bottom of scale
    '{RST_MIN_SP, RST_MAX_SP, RST_INIT_SP, RST_BAND, RST_STEP}
  };

  // Idling patterns, one per chunk: none, source, sink, both
  localparam int SEND_IDLE_OF [4]  = '{0, 80, 0, 20};
  localparam int RECV_STALL_OF [4] = '{0, 0, 80, 20};

  logic clk = 1'b0;
  logic rst;

  wht_sample_if #(.ADC_BITS(ADC_BITS)) sample_ch ();
  wht_result_if                        result_ch ();
  wht_cfg_if                           cfg_ch ();

  water_heater_thermostat_unit #(
    .SAMPLES_PER_DECISION (DECISION_EVERY),
    .ADC_BITS             (ADC_BITS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model state of the controller
  cfg_t             conf;
  logic [SP_W-1:0]  sp_now;
  logic             powered;
  logic [CNT_W-1:0] smp_count;
  logic             heat, cool, lamp;
  logic [SEG_W-1:0] ones_shown, tens_shown;

  res_t expected_results [$];
  int   errors = 0;

  // Idling control, written by the main sequence only
  int send_idle  = 0;
  int recv_stall = 0;
  int hold_reqs  = 0;

  // One sample period of the controller; returns the result it leaves
  function automatic res_t thermostat_step(reading_t rd);
    int   scaled;
    int   nxt;
    logic tick;
    tick = 1'b0;
    if (rd.toggle) powered = !powered;
    if (powered) begin
      scaled    = int'(rd.adc) * SCALE_MAX / ADC_FULL;
      smp_count = smp_count + 1'b1;
      if (smp_count >= DECISION_EVERY) begin
        ones_shown = DIGIT_SEGS[scaled % 10];
        tens_shown = (scaled / 10 < 10) ? DIGIT_SEGS[scaled / 10] : SEG_BLANK;
        // signed compare: the low threshold may sit below zero
        heat      = scaled < int'(sp_now) - int'(conf.band);
        cool      = scaled > int'(sp_now) + int'(conf.band);
        lamp      = cool;
        smp_count = '0;
        tick      = 1'b1;
      end
      if (rd.up && sp_now < conf.max_sp) begin
        nxt    = int'(sp_now) + int'(conf.step);
        sp_now = (nxt > int'(conf.max_sp)) ? conf.max_sp : nxt[SP_W-1:0];
      end
      if (rd.down && sp_now > conf.min_sp) begin
        if (int'(sp_now) >= int'(conf.min_sp) + int'(conf.step))
          sp_now = sp_now - conf.step;
        else
          sp_now = conf.min_sp;
      end
    end else begin
      heat       = 1'b0;
      cool       = 1'b0;
      lamp       = 1'b0;
      ones_shown = SEG_BLANK;
      tens_shown = SEG_BLANK;
    end
    return '{heat, cool, lamp, ones_shown, tens_shown, sp_now, tick};
  endfunction

  function automatic void check_field(string name, logic [SP_W-1:0] want,
                                      logic [SP_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Offer one sample after a random gap, wait for its transfer, then
  // record what the controller should answer
  task automatic offer(reading_t rd, logic typed, res_t want);
    res_t pred;
    while ($urandom_range(99) < send_idle) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid        <= 1'b1;
    sample_ch.adc_sample   <= rd.adc;
    sample_ch.up_pressed   <= rd.up;
    sample_ch.down_pressed <= rd.down;
    sample_ch.power_toggle <= rd.toggle;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    pred = thermostat_step(rd);
    expected_results.push_back(typed ? want : pred);
  endtask

  // Register write; the caller lowers valid after its last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_MIN_SP:  conf.min_sp = val;
      REG_MAX_SP:  conf.max_sp = val;
      REG_BAND:    conf.band   = val[PARAM_W-1:0];
      REG_STEP:    conf.step   = val[PARAM_W-1:0];
      REG_INIT_SP: begin
        conf.init_sp = val;
        sp_now       = val;   // setpoint follows at once
      end
      default: ;
    endcase
  endtask

  task automatic apply_plan(cfg_t plan);
    logic [2:0] junk;
    write_reg(CFG_IDX_W'(FIRST_SPARE_REG + $urandom_range(2)),
              CFG_DATA_W'($urandom_range(511)));
    write_reg(REG_MIN_SP, plan.min_sp);
    write_reg(REG_MAX_SP, plan.max_sp);
    // upper data bits are don't-care for the 6-bit registers
    junk = 3'($urandom_range(7));
    write_reg(REG_BAND, {junk, plan.band});
    junk = 3'($urandom_range(7));
    write_reg(REG_STEP, {junk, plan.step});
    write_reg(REG_INIT_SP, plan.init_sp);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random samples, mostly powered, with a share aimed at the thresholds
  task automatic run_random(int count);
    reading_t rd;
    int       tgt;
    repeat (count) begin
      case ($urandom_range(7))
        0: rd.adc = '0;
        1: rd.adc = '1;
        2, 3: begin
          tgt = int'(sp_now) + ($urandom_range(1) ? int'(conf.band) : -int'(conf.band))
                + int'($urandom_range(4)) - 2;
          if (tgt < 0) tgt = 0;
          if (tgt > SCALE_MAX) tgt = SCALE_MAX;
          tgt = (tgt * ADC_FULL + SCALE_MAX - 1) / SCALE_MAX;
          rd.adc = (tgt > ADC_FULL) ? ADC_BITS'(ADC_FULL) : ADC_BITS'(tgt);
        end
        default: rd.adc = ADC_BITS'($urandom_range(ADC_FULL));
      endcase
      rd.up     = ($urandom_range(3) == 0);
      rd.down   = ($urandom_range(3) == 0);
      rd.toggle = powered ? ($urandom_range(99) < 2) : ($urandom_range(99) < 30);
      offer(rd, 1'b0, UNTYPED);
    end
  endtask

  // Let every outstanding result arrive so the unit is idle
  task automatic settle();
    int waited;
    sample_ch.valid <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_results.size() != 0) begin
      errors += expected_results.size();
      $display("%0t: %0d results outstanding, expected 0", $time,
               expected_results.size());
      expected_results.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  // Result sink: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_reqs != holds_served) begin
        holds_served++;
        hold_left       = HOLD_CYCLES - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // Result checker: each transfer against the oldest expectation
  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got setpoint %0d", $time,
                 result_ch.current_setpoint);
      end else begin
        want = expected_results.pop_front();
        check_field("heater_on",        want.heater_on,        result_ch.heater_on);
        check_field("cooler_on",        want.cooler_on,        result_ch.cooler_on);
        check_field("cool_indicator",   want.cool_indicator,   result_ch.cool_indicator);
        check_field("seg_ones",         want.seg_ones,         result_ch.seg_ones);
        check_field("seg_tens",         want.seg_tens,         result_ch.seg_tens);
        check_field("current_setpoint", want.current_setpoint, result_ch.current_setpoint);
        check_field("decision_made",    want.decision_made,    result_ch.decision_made);
      end
    end
  end

  // Main sequence
  initial begin
    rst                    = 1'b1;
    sample_ch.valid        = 1'b0;
    sample_ch.adc_sample   = '0;
    sample_ch.up_pressed   = 1'b0;
    sample_ch.down_pressed = 1'b0;
    sample_ch.power_toggle = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = '0;
    cfg_ch.data            = '0;

    conf       = '{RST_MIN_SP, RST_MAX_SP, RST_INIT_SP, RST_BAND, RST_STEP};
    sp_now     = RST_INIT_SP;
    powered    = 1'b0;
    smp_count  = '0;
    heat       = 1'b0;
    cool       = 1'b0;
    lamp       = 1'b0;
    ones_shown = SEG_BLANK;
    tens_shown = SEG_BLANK;

    send_idle  = 20;
    recv_stall = 20;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed table under the reset register values
    for (int i = 0; i < NUM_DIRECTED; i++)
      offer(DIRECTED[i].rd, DIRECTED[i].typed, DIRECTED[i].want);
    settle();

    // Random samples under each setting, one chunk per idling pattern
    for (int k = 0; k < NUM_PLANS; k++) begin
      apply_plan(CFG_PLAN[k]);
      for (int m = 0; m < 4; m++) begin
        send_idle  = SEND_IDLE_OF[m];
        recv_stall = RECV_STALL_OF[m];
        run_random(CHUNK_ITEMS);
      end
      if (k == 0) begin
        // sink holds off while the source keeps offering: the unit fills
        // and stops taking samples until the hold ends
        send_idle  = 0;
        recv_stall = 0;
        hold_reqs++;
        run_random(PRESSURE_ITEMS);
      end
      settle();
    end

    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

endmodule
